[hdl/lru_page_replacement_defines.svh]
// Assertion macros used by the lru_page_replacement design file.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// Condition implies consequence in the same cycle.
`define LRUPR_ASSERT_NOW(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("lru_page_replacement: check failed");

// Condition implies consequence in the next cycle.
`define LRUPR_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("lru_page_replacement: check failed");

`else

`define LRUPR_ASSERT_NOW(lbl, clk, rstn, cond, cons)
`define LRUPR_ASSERT_NEXT(lbl, clk, rstn, cond, cons)

`endif

`endif

[hdl/lrupr_pkg.sv]
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int CFG_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int FAULT_W = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

endpackage

[hdl/lrupr_if.sv]
`timescale 1ns / 1ps

interface lrupr_page_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_result_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [lrupr_pkg::SLOT_W-1:0]     slot;
  logic                             evicted_valid;
  logic [PAGE_BITS-1:0]             evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]    fault_total;

  modport source (
    output valid, output hit, output slot, output evicted_valid,
    output evicted_page, output fault_total, input ready
  );
  modport sink (
    input valid, input hit, input slot, input evicted_valid,
    input evicted_page, input fault_total, output ready
  );
endinterface

[hdl/lrupr_frame_cell.sv]
`timescale 1ns / 1ps

module lrupr_frame_cell #(
  parameter int PAGE_BITS = 16,
  parameter int NW        = 4,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NW-1:0]        n_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 wr_i,
  input  logic                 found_i,
  output logic                 found_o,
  output logic                 sel_o,
  output logic                 valid_o,
  output logic [PAGE_BITS-1:0] page_o
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic                 match;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      page_q <= page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= 1'b1;
    end
  end

  assign match   = (NW'(IDX) < n_i) && valid_q && (page_q == page_i);
  assign sel_o   = match && !found_i;
  assign found_o = found_i || match;
  assign valid_o = valid_q;
  assign page_o  = page_q;

endmodule

[hdl/lrupr_rank_cell.sv]
`timescale 1ns / 1ps

module lrupr_rank_cell #(
  parameter int SW  = 3,
  parameter int NW  = 4,
  parameter int POS = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          update_i,
  input  logic [SW-1:0] touch_slot_i,
  input  logic [SW-1:0] next_id_i,
  input  logic [NW-1:0] n_i,
  input  logic          tfound_i,
  output logic          tfound_o,
  input  logic          vfound_i,
  output logic          vfound_o,
  output logic          vsel_o,
  output logic [SW-1:0] id_o
);

  logic [SW-1:0] id_q;
  logic          cand;

  assign tfound_o = tfound_i || (id_q == touch_slot_i);

  // advance from the neighbor once the touched slot is at or below this position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q <= SW'(POS);
    end else if (update_i && tfound_o) begin
      id_q <= next_id_i;
    end
  end

  assign cand     = NW'(id_q) < n_i;
  assign vsel_o   = cand && !vfound_i;
  assign vfound_o = vfound_i || cand;
  assign id_o     = id_q;

endmodule

[hdl/lru_page_replacement.sv]
`timescale 1ns / 1ps
// Channel    Dir  Payload                                                  Transfer
// page_i     in   page                                                     valid & ready
// result_o   out  hit, slot, evicted_valid, evicted_page, fault_total      valid & ready
// cfg        in   cfg_data_i (frames_in_use)                               cfg_we_i
//
// One reference is looked up and the frame and recency cells are updated in the cycle
// of its transfer; the result appears in the output register on the next cycle.
// Up to one reference per cycle; the rate is set by the single output register.
// page_i.ready drops only while a result is held and result_o.ready is low.
// Reset clears frame valid bits, fill count and fault count, sets the recency order
// to ascending slots and the frame count to eight.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0]     cfg_data_i,
  lrupr_page_if.sink                      page_i,
  lrupr_result_if.source                  result_o
);

  localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FW = $clog2(FRAMES + 1);
  localparam int NW = (FW > lrupr_pkg::CFG_W) ? FW : lrupr_pkg::CFG_W;
  localparam int SLW = lrupr_pkg::SLOT_W;

  logic [lrupr_pkg::CFG_W-1:0]   cfg_q;
  logic [FW-1:0]                 filled_q;
  logic [lrupr_pkg::FAULT_W-1:0] fault_q;
  logic                          out_valid_q;
  logic                          hit_q;
  logic [SLW-1:0]                slot_q;
  logic                          ev_valid_q;
  logic [PAGE_BITS-1:0]          ev_page_q;

  logic                 accept;
  logic [NW-1:0]        n_w;
  logic                 fill;
  logic                 hit;
  logic [SW-1:0]        hit_slot;
  logic [SW-1:0]        victim;
  logic [SW-1:0]        tslot;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic [SW+SLW-1:0]    slot_ext;
  logic [FRAMES-1:0]    perm;

  logic [FRAMES:0]      hchain;
  logic [FRAMES:0]      tchain;
  logic [FRAMES:0]      vchain;
  logic [FRAMES-1:0]    fsel;
  logic [FRAMES-1:0]    fvalid;
  logic [FRAMES-1:0]    vsel;
  logic [PAGE_BITS-1:0] fpage [FRAMES];
  logic [SW-1:0]        ids   [FRAMES];
  logic [SW-1:0]        nexts [FRAMES];

  assign page_i.ready = !out_valid_q || result_o.ready;
  assign accept       = page_i.valid && page_i.ready;

  always_comb begin
    if (cfg_q == '0) begin
      n_w = NW'(1);
    end else if (NW'(cfg_q) > NW'(FRAMES)) begin
      n_w = NW'(FRAMES);
    end else begin
      n_w = NW'(cfg_q);
    end
  end

  assign hchain[0] = 1'b0;
  assign tchain[0] = 1'b0;
  assign vchain[0] = 1'b0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cells
    lrupr_frame_cell #(
      .PAGE_BITS (PAGE_BITS),
      .NW        (NW),
      .IDX       (g)
    ) u_frame (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .n_i     (n_w),
      .page_i  (page_i.page),
      .wr_i    (accept && !hit && (tslot == SW'(g))),
      .found_i (hchain[g]),
      .found_o (hchain[g+1]),
      .sel_o   (fsel[g]),
      .valid_o (fvalid[g]),
      .page_o  (fpage[g])
    );

    if (g == FRAMES - 1) begin : g_last
      assign nexts[g] = tslot;
    end else begin : g_mid
      assign nexts[g] = ids[g+1];
    end

    lrupr_rank_cell #(
      .SW  (SW),
      .NW  (NW),
      .POS (g)
    ) u_rank (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .update_i     (accept),
      .touch_slot_i (tslot),
      .next_id_i    (nexts[g]),
      .n_i          (n_w),
      .tfound_i     (tchain[g]),
      .tfound_o     (tchain[g+1]),
      .vfound_i     (vchain[g]),
      .vfound_o     (vchain[g+1]),
      .vsel_o       (vsel[g]),
      .id_o         (ids[g])
    );
  end

  assign hit  = hchain[FRAMES];
  assign fill = NW'(filled_q) < n_w;

  always_comb begin
    hit_slot = '0;
    victim   = '0;
    perm     = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (fsel[i]) begin
        hit_slot = hit_slot | SW'(i);
      end
      if (vsel[i]) begin
        victim = victim | ids[i];
      end
      perm[ids[i]] = 1'b1;
    end
  end

  always_comb begin
    ev_valid = 1'b0;
    ev_page  = '0;
    if (hit) begin
      tslot = hit_slot;
    end else if (fill) begin
      tslot = filled_q[SW-1:0];
    end else begin
      tslot = victim;
      if (fvalid[victim]) begin
        ev_valid = 1'b1;
        ev_page  = fpage[victim];
      end
    end
  end

  assign slot_ext = {{SLW{1'b0}}, tslot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lrupr_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept && !hit) begin
        if (fault_q != '1) begin
          fault_q <= fault_q + 1'b1;
        end
        if (fill) begin
          filled_q <= filled_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q      <= hit;
      slot_q     <= slot_ext[SLW-1:0];
      ev_valid_q <= ev_valid;
      ev_page_q  <= ev_page;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.hit           = hit_q;
  assign result_o.slot          = slot_q;
  assign result_o.evicted_valid = ev_valid_q;
  assign result_o.evicted_page  = ev_page_q;
  assign result_o.fault_total   = fault_q;

  `LRUPR_ASSERT_NOW(a_hit_no_evict, clk_i, rst_ni, out_valid_q && hit_q, !ev_valid_q)
  `LRUPR_ASSERT_NEXT(a_accept_fills_out, clk_i, rst_ni, accept, out_valid_q)
  `LRUPR_ASSERT_NOW(a_order_is_perm, clk_i, rst_ni, 1'b1, &perm)
  `LRUPR_ASSERT_NEXT(a_fault_monotonic, clk_i, rst_ni, accept, fault_q >= $past(fault_q))

endmodule
